FILE: sv/tlc_pkg.sv
`timescale 1ns / 1ps

package tlc_pkg;

  localparam int NEAR_DEPTH = 16;
  localparam int FAR_DEPTH  = 64;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 64;
  localparam int POS_BITS   = 7;
  localparam int NIDX_BITS  = 4;
  localparam int FIDX_BITS  = 6;

  // Operation codes
  localparam logic [1:0] OP_GET  = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_MISS = 2'd0;
  localparam logic [1:0] ST_NEAR = 2'd1;
  localparam logic [1:0] ST_FAR  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Register indexes
  localparam logic REG_NEAR_CAP = 1'b0;
  localparam logic REG_FAR_CAP  = 1'b1;

  typedef struct packed {
    logic [1:0]            operation;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] store_value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] read_value;
    logic                  spilled;
    logic                  dropped;
    logic [KEY_BITS-1:0]   dropped_key;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FRONT,
    CELL_REMOVE
  } cell_op_t;

  // Broadcast control for one chain of cells
  typedef struct packed {
    cell_op_t              kind;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   fill;
    logic [KEY_BITS-1:0]   cmp_key;
    logic [KEY_BITS-1:0]   load_key;
    logic [VALUE_BITS-1:0] load_val;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ACT,
    S_SPILL_CHK,
    S_SPILL,
    S_PREP,
    S_RELOOK,
    S_REFRONT
  } state_t;

  // Lowest set flag: {found, index}
  function automatic logic [FIDX_BITS:0] first_hit(input logic [FAR_DEPTH-1:0] v);
    logic [FIDX_BITS:0] r;
    r = '0;
    for (int i = FAR_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, FIDX_BITS'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] near_eff(input logic [4:0] c);
    logic [4:0] r;
    r = c;
    if (c == 5'd0) begin
      r = 5'd1;
    end else if (c > 5'(NEAR_DEPTH)) begin
      r = 5'(NEAR_DEPTH);
    end
    return r;
  endfunction

  function automatic logic [6:0] far_eff(input logic [6:0] c);
    logic [6:0] r;
    r = c;
    if (c == 7'd0) begin
      r = 7'd1;
    end else if (c > 7'(FAR_DEPTH)) begin
      r = 7'(FAR_DEPTH);
    end
    return r;
  endfunction

endpackage

FILE: sv/tlc_cell.sv
`timescale 1ns / 1ps

module tlc_cell (
  input  logic                                clk,
  input  tlc_pkg::cell_ctl_t                  ctl,
  input  logic [tlc_pkg::POS_BITS-1:0]        pos_id,
  input  logic [tlc_pkg::KEY_BITS-1:0]        left_key,
  input  logic [tlc_pkg::VALUE_BITS-1:0]      left_val,
  input  logic [tlc_pkg::KEY_BITS-1:0]        right_key,
  input  logic [tlc_pkg::VALUE_BITS-1:0]      right_val,
  output logic [tlc_pkg::KEY_BITS-1:0]        key,
  output logic [tlc_pkg::VALUE_BITS-1:0]      val,
  output logic                                match
);

  // Entry update: load at front, shift from left or right neighbour
  always_ff @(posedge clk) begin
    case (ctl.kind)
      tlc_pkg::CELL_FRONT: begin
        if (pos_id == '0) begin
          key <= ctl.load_key;
          val <= ctl.load_val;
        end else if (pos_id <= ctl.pos) begin
          key <= left_key;
          val <= left_val;
        end
      end
      tlc_pkg::CELL_REMOVE: begin
        if (pos_id >= ctl.pos) begin
          key <= right_key;
          val <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

  // Only occupied entries take part in a search
  assign match = (pos_id < ctl.fill) && (key == ctl.cmp_key);

endmodule

FILE: sv/two_level_lru_key_cache.sv
`timescale 1ns / 1ps

// Two-tier LRU key store built as two chains of cells (16 near, 64 far), each kept in
// most- to least-recently-used order. A transaction is taken when start is high and busy
// is low; its result appears on response with done high for exactly one cycle, and the
// receiver cannot stall it. Every step is either a parallel key compare across a chain
// (registered) or one shift of a chain, run in turn by the sequencer. A new transaction
// may start in the cycle done is shown. Capacities are to be written over the APB port
// only while idle; the user must keep to this, as the block itself does not enforce it.
module two_level_lru_key_cache (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  tlc_pkg::req_t        request,
  output logic                 done,
  output tlc_pkg::rsp_t        response,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  tlc_pkg::state_t state, state_next;
  tlc_pkg::req_t   req_q;
  tlc_pkg::rsp_t   rsp_next;
  logic            done_next;
  logic [4:0]      near_capacity;
  logic [6:0]      far_capacity;
  logic [4:0]      near_count, near_count_next;
  logic [6:0]      far_count, far_count_next;
  logic [tlc_pkg::VALUE_BITS-1:0] pval, pval_next;
  logic [tlc_pkg::NEAR_DEPTH-1:0] nm, nm_q;
  logic [tlc_pkg::FAR_DEPTH-1:0]  fm, fm_q;
  logic [tlc_pkg::KEY_BITS-1:0]   nk [tlc_pkg::NEAR_DEPTH];
  logic [tlc_pkg::VALUE_BITS-1:0] nv [tlc_pkg::NEAR_DEPTH];
  logic [tlc_pkg::KEY_BITS-1:0]   fk [tlc_pkg::FAR_DEPTH];
  logic [tlc_pkg::VALUE_BITS-1:0] fv [tlc_pkg::FAR_DEPTH];
  tlc_pkg::cell_ctl_t near_ctl, far_ctl;
  logic [tlc_pkg::FIDX_BITS:0]    nh, fh;
  logic [tlc_pkg::NIDX_BITS-1:0]  n_idx;
  logic [tlc_pkg::FIDX_BITS-1:0]  f_idx;
  logic [4:0] n_last, ncap;
  logic [6:0] f_last, fcap;
  logic       cfg_wr;

  // Near chain
  for (genvar i = 0; i < tlc_pkg::NEAR_DEPTH; i++) begin : g_near
    logic [tlc_pkg::KEY_BITS-1:0]   lk, rk;
    logic [tlc_pkg::VALUE_BITS-1:0] lv, rv;
    if (i == 0) begin : g_l0
      assign lk = '0;
      assign lv = '0;
    end else begin : g_l
      assign lk = nk[i-1];
      assign lv = nv[i-1];
    end
    if (i == tlc_pkg::NEAR_DEPTH - 1) begin : g_r0
      assign rk = '0;
      assign rv = '0;
    end else begin : g_r
      assign rk = nk[i+1];
      assign rv = nv[i+1];
    end
    tlc_cell u_cell (
      .clk(clk), .ctl(near_ctl), .pos_id(tlc_pkg::POS_BITS'(i)),
      .left_key(lk), .left_val(lv), .right_key(rk), .right_val(rv),
      .key(nk[i]), .val(nv[i]), .match(nm[i])
    );
  end

  // Far chain
  for (genvar i = 0; i < tlc_pkg::FAR_DEPTH; i++) begin : g_far
    logic [tlc_pkg::KEY_BITS-1:0]   lk, rk;
    logic [tlc_pkg::VALUE_BITS-1:0] lv, rv;
    if (i == 0) begin : g_l0
      assign lk = '0;
      assign lv = '0;
    end else begin : g_l
      assign lk = fk[i-1];
      assign lv = fv[i-1];
    end
    if (i == tlc_pkg::FAR_DEPTH - 1) begin : g_r0
      assign rk = '0;
      assign rv = '0;
    end else begin : g_r
      assign rk = fk[i+1];
      assign rv = fv[i+1];
    end
    tlc_cell u_cell (
      .clk(clk), .ctl(far_ctl), .pos_id(tlc_pkg::POS_BITS'(i)),
      .left_key(lk), .left_val(lv), .right_key(rk), .right_val(rv),
      .key(fk[i]), .val(fv[i]), .match(fm[i])
    );
  end

  assign busy   = (state != tlc_pkg::S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tlc_pkg::REG_FAR_CAP) ? {25'd0, far_capacity}
                                                     : {27'd0, near_capacity};

  // Hit decode and tail pointers
  assign nh     = tlc_pkg::first_hit({{(tlc_pkg::FAR_DEPTH-tlc_pkg::NEAR_DEPTH){1'b0}}, nm_q});
  assign fh     = tlc_pkg::first_hit(fm_q);
  assign n_idx  = nh[tlc_pkg::NIDX_BITS-1:0];
  assign f_idx  = fh[tlc_pkg::FIDX_BITS-1:0];
  assign n_last = near_count - 5'd1;
  assign f_last = far_count - 7'd1;
  assign ncap   = tlc_pkg::near_eff(near_capacity);
  assign fcap   = tlc_pkg::far_eff(far_capacity);

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tlc_pkg::S_IDLE;
      done          <= 1'b0;
      near_count    <= '0;
      far_count     <= '0;
      near_capacity <= 5'd16;
      far_capacity  <= 7'd64;
    end else begin
      state      <= state_next;
      done       <= done_next;
      near_count <= near_count_next;
      far_count  <= far_count_next;
      if (cfg_wr) begin
        if (paddr[2] == tlc_pkg::REG_NEAR_CAP) begin
          near_capacity <= pwdata[4:0];
        end else begin
          far_capacity <= pwdata[6:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    response <= rsp_next;
    pval     <= pval_next;
    if (state == tlc_pkg::S_IDLE && start) begin
      req_q <= request;
    end
    if (state == tlc_pkg::S_LOOK) begin
      nm_q <= nm;
    end
    if (state == tlc_pkg::S_LOOK || state == tlc_pkg::S_SPILL_CHK ||
        state == tlc_pkg::S_RELOOK) begin
      fm_q <= fm;
    end
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    done_next       = 1'b0;
    rsp_next        = response;
    pval_next       = pval;
    near_count_next = near_count;
    far_count_next  = far_count;
    near_ctl        = '{kind: tlc_pkg::CELL_HOLD, pos: '0, fill: {2'b00, near_count},
                        cmp_key: req_q.lookup_key, load_key: req_q.lookup_key,
                        load_val: pval};
    far_ctl         = '{kind: tlc_pkg::CELL_HOLD, pos: '0, fill: far_count,
                        cmp_key: req_q.lookup_key, load_key: req_q.lookup_key,
                        load_val: pval};
    case (state)
      tlc_pkg::S_IDLE: begin
        if (start) begin
          rsp_next   = '0;
          state_next = tlc_pkg::S_LOOK;
        end
      end
      tlc_pkg::S_LOOK: begin
        state_next = tlc_pkg::S_ACT;
      end
      tlc_pkg::S_ACT: begin
        case (req_q.operation)
          tlc_pkg::OP_GET: begin
            if (nh[tlc_pkg::FIDX_BITS]) begin
              near_ctl.kind       = tlc_pkg::CELL_FRONT;
              near_ctl.pos        = tlc_pkg::POS_BITS'(n_idx);
              near_ctl.load_key   = nk[n_idx];
              near_ctl.load_val   = nv[n_idx];
              rsp_next.status     = tlc_pkg::ST_NEAR;
              rsp_next.read_value = nv[n_idx];
              done_next           = 1'b1;
              state_next          = tlc_pkg::S_IDLE;
            end else if (fh[tlc_pkg::FIDX_BITS]) begin
              pval_next           = fv[f_idx];
              rsp_next.status     = tlc_pkg::ST_FAR;
              rsp_next.read_value = fv[f_idx];
              state_next          = tlc_pkg::S_SPILL_CHK;
            end else begin
              done_next  = 1'b1;
              state_next = tlc_pkg::S_IDLE;
            end
          end
          tlc_pkg::OP_PUT, tlc_pkg::OP_DEL: begin
            if (nh[tlc_pkg::FIDX_BITS]) begin
              near_ctl.kind   = tlc_pkg::CELL_REMOVE;
              near_ctl.pos    = tlc_pkg::POS_BITS'(n_idx);
              near_count_next = near_count - 5'd1;
            end
            if (fh[tlc_pkg::FIDX_BITS]) begin
              far_ctl.kind   = tlc_pkg::CELL_REMOVE;
              far_ctl.pos    = tlc_pkg::POS_BITS'(f_idx);
              far_count_next = far_count - 7'd1;
            end
            rsp_next.status = tlc_pkg::ST_DONE;
            pval_next       = req_q.store_value;
            if (req_q.operation == tlc_pkg::OP_PUT) begin
              state_next = tlc_pkg::S_SPILL_CHK;
            end else begin
              done_next  = 1'b1;
              state_next = tlc_pkg::S_IDLE;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = tlc_pkg::S_IDLE;
          end
        endcase
      end
      tlc_pkg::S_SPILL_CHK: begin
        // Search the far tier for the near LRU key
        far_ctl.cmp_key = nk[n_last[tlc_pkg::NIDX_BITS-1:0]];
        if (near_count >= ncap) begin
          state_next = tlc_pkg::S_SPILL;
        end else begin
          state_next = tlc_pkg::S_PREP;
        end
      end
      tlc_pkg::S_SPILL: begin
        far_ctl.kind = tlc_pkg::CELL_FRONT;
        if (fh[tlc_pkg::FIDX_BITS]) begin
          far_ctl.pos      = tlc_pkg::POS_BITS'(f_idx);
          far_ctl.load_key = fk[f_idx];
          far_ctl.load_val = fv[f_idx];
        end else begin
          far_ctl.load_key  = nk[n_last[tlc_pkg::NIDX_BITS-1:0]];
          far_ctl.load_val  = nv[n_last[tlc_pkg::NIDX_BITS-1:0]];
          rsp_next.spilled  = 1'b1;
          if (far_count >= fcap) begin
            rsp_next.dropped     = 1'b1;
            rsp_next.dropped_key = fk[f_last[tlc_pkg::FIDX_BITS-1:0]];
            far_ctl.pos          = f_last;
          end else begin
            far_ctl.pos    = far_count;
            far_count_next = far_count + 7'd1;
          end
        end
        near_count_next = near_count - 5'd1;
        state_next      = tlc_pkg::S_PREP;
      end
      tlc_pkg::S_PREP: begin
        near_ctl.kind   = tlc_pkg::CELL_FRONT;
        near_ctl.pos    = {2'b00, near_count};
        near_count_next = near_count + 5'd1;
        if (req_q.operation == tlc_pkg::OP_GET) begin
          state_next = tlc_pkg::S_RELOOK;
        end else begin
          done_next  = 1'b1;
          state_next = tlc_pkg::S_IDLE;
        end
      end
      tlc_pkg::S_RELOOK: begin
        state_next = tlc_pkg::S_REFRONT;
      end
      tlc_pkg::S_REFRONT: begin
        if (fh[tlc_pkg::FIDX_BITS]) begin
          far_ctl.kind     = tlc_pkg::CELL_FRONT;
          far_ctl.pos      = tlc_pkg::POS_BITS'(f_idx);
          far_ctl.load_key = fk[f_idx];
          far_ctl.load_val = fv[f_idx];
        end
        done_next  = 1'b1;
        state_next = tlc_pkg::S_IDLE;
      end
      default: begin
        state_next = tlc_pkg::S_IDLE;
      end
    endcase
    // Lowering a capacity cuts the fill back
    if (cfg_wr) begin
      if (paddr[2] == tlc_pkg::REG_NEAR_CAP) begin
        if (near_count > tlc_pkg::near_eff(pwdata[4:0])) begin
          near_count_next = tlc_pkg::near_eff(pwdata[4:0]);
        end
      end else begin
        if (far_count > tlc_pkg::far_eff(pwdata[6:0])) begin
          far_count_next = tlc_pkg::far_eff(pwdata[6:0]);
        end
      end
    end
  end

  // Checks
  a_near_fill: assert property (@(posedge clk) disable iff (rst)
    near_count <= 5'(tlc_pkg::NEAR_DEPTH)) else $error("near fill overflow");
  a_far_fill: assert property (@(posedge clk) disable iff (rst)
    far_count <= 7'(tlc_pkg::FAR_DEPTH)) else $error("far fill overflow");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("result strobe outside a transaction");
  a_drop_spill: assert property (@(posedge clk) disable iff (rst)
    done && response.dropped |-> response.spilled) else $error("drop without spill");

endmodule

FILE: bench/two_level_lru_key_cache_tb.sv
`timescale 1ns / 1ps

module two_level_lru_key_cache_tb;
  import tlc_pkg::*;

  // Model of both tiers and the expected responses still in flight
  class lru_scoreboard;
    logic [KEY_BITS-1:0]   nkey[NEAR_DEPTH];
    logic [VALUE_BITS-1:0] nval[NEAR_DEPTH];
    logic [KEY_BITS-1:0]   fkey[FAR_DEPTH];
    logic [VALUE_BITS-1:0] fval[FAR_DEPTH];
    int ncount, fcount;
    int ncap_reg, fcap_reg;
    rsp_t pending[$];
    int errors;
    rsp_t cur;

    function void reset_state();
      ncount = 0; fcount = 0;
      ncap_reg = 16; fcap_reg = 64;
      pending.delete();
      errors = 0;
    endfunction

    function int ncap();
      if (ncap_reg < 1) return 1;
      if (ncap_reg > NEAR_DEPTH) return NEAR_DEPTH;
      return ncap_reg;
    endfunction

    function int fcap();
      if (fcap_reg < 1) return 1;
      if (fcap_reg > FAR_DEPTH) return FAR_DEPTH;
      return fcap_reg;
    endfunction

    function void set_capacity(bit which, int value);
      if (which == REG_NEAR_CAP) begin
        ncap_reg = value & 'h1f;
        if (ncount > ncap()) ncount = ncap();
      end else begin
        fcap_reg = value & 'h7f;
        if (fcount > fcap()) fcount = fcap();
      end
    endfunction

    function int near_find(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < ncount; i++) if (nkey[i] == k) return i;
      return -1;
    endfunction

    function int far_find(logic [KEY_BITS-1:0] k);
      for (int i = 0; i < fcount; i++) if (fkey[i] == k) return i;
      return -1;
    endfunction

    function void near_front(int idx);
      logic [KEY_BITS-1:0] k;
      logic [VALUE_BITS-1:0] v;
      k = nkey[idx]; v = nval[idx];
      for (int i = idx; i > 0; i--) begin nkey[i] = nkey[i-1]; nval[i] = nval[i-1]; end
      nkey[0] = k; nval[0] = v;
    endfunction

    function void far_front(int idx);
      logic [KEY_BITS-1:0] k;
      logic [VALUE_BITS-1:0] v;
      k = fkey[idx]; v = fval[idx];
      for (int i = idx; i > 0; i--) begin fkey[i] = fkey[i-1]; fval[i] = fval[i-1]; end
      fkey[0] = k; fval[0] = v;
    endfunction

    function void far_insert(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
      int idx;
      idx = far_find(k);
      if (idx >= 0) begin
        far_front(idx);
        return;
      end
      if (fcount >= fcap()) begin
        cur.dropped = 1'b1;
        cur.dropped_key = fkey[fcount-1];
        fcount--;
      end
      for (int i = fcount; i > 0; i--) begin fkey[i] = fkey[i-1]; fval[i] = fval[i-1]; end
      fkey[0] = k; fval[0] = v;
      fcount++;
      cur.spilled = 1'b1;
    endfunction

    function void near_insert(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
      if (ncount >= ncap()) begin
        far_insert(nkey[ncount-1], nval[ncount-1]);
        ncount--;
      end
      for (int i = ncount; i > 0; i--) begin nkey[i] = nkey[i-1]; nval[i] = nval[i-1]; end
      nkey[0] = k; nval[0] = v;
      ncount++;
    endfunction

    function void drop_key(logic [KEY_BITS-1:0] k);
      int idx;
      idx = near_find(k);
      if (idx >= 0) begin
        for (int i = idx; i + 1 < ncount; i++) begin
          nkey[i] = nkey[i+1]; nval[i] = nval[i+1];
        end
        ncount--;
      end
      idx = far_find(k);
      if (idx >= 0) begin
        for (int i = idx; i + 1 < fcount; i++) begin
          fkey[i] = fkey[i+1]; fval[i] = fval[i+1];
        end
        fcount--;
      end
    endfunction

    // Apply one accepted command and queue its response
    function void note_request(req_t r);
      int idx;
      cur = '0;
      case (r.operation)
        OP_GET: begin
          idx = near_find(r.lookup_key);
          if (idx >= 0) begin
            near_front(idx);
            cur.status = ST_NEAR;
            cur.read_value = nval[0];
          end else begin
            idx = far_find(r.lookup_key);
            if (idx >= 0) begin
              cur.read_value = fval[idx];
              cur.status = ST_FAR;
              near_insert(r.lookup_key, fval[idx]);
              idx = far_find(r.lookup_key);
              if (idx >= 0) far_front(idx);
            end
          end
        end
        OP_PUT: begin
          drop_key(r.lookup_key);
          near_insert(r.lookup_key, r.store_value);
          cur.status = ST_DONE;
        end
        OP_DEL: begin
          drop_key(r.lookup_key);
          cur.status = ST_DONE;
        end
        default: ;
      endcase
      pending.push_back(cur);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value exp %h got %h", $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.spilled !== want.spilled) begin
        $display("%0t: spilled exp %b got %b", $time, want.spilled, got.spilled);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $display("%0t: dropped exp %b got %b", $time, want.dropped, got.dropped);
        errors++;
      end
      if (got.dropped_key !== want.dropped_key) begin
        $display("%0t: dropped_key exp %h got %h", $time, want.dropped_key,
                 got.dropped_key);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        done;
  rsp_t        response;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_scoreboard sb;
  int idle_pct;
  int stall_cycles;
  logic [KEY_BITS-1:0] key_pool[24];

  two_level_lru_key_cache i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .response(response), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Clock starts low so the first rising edge comes after reset is applied
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Score accepted transactions and responses; watchdog on silence
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (start && !busy) sb.note_request(request);
      if (done) sb.check_response(response);
      if ((start && !busy) || done || psel) begin
        stall_cycles <= 0;
      end else if (sb.pending.size() > 0 || start) begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 2000) begin
          $display("two_level_lru_key_cache_tb failed");
          $finish;
        end
      end
    end
  end

  // Issue one command; start stays high across back-to-back commands
  task automatic send(logic [1:0] op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= '{operation: op, lookup_key: k, store_value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(bit which, int value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= (which == REG_FAR_CAP) ? 3'd4 : 3'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_capacity(which, value);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(9) < 8) return key_pool[$urandom_range(23)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 50) op = OP_GET;
      else if (r < 85) op = OP_PUT;
      else if (r < 97) op = OP_DEL;
      else op = 2'd3;
      send(op, pick_key(), $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1'b1; start = 1'b0; request = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0;
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny tiers so spills, refreshes and drops show quickly
    write_reg(REG_NEAR_CAP, 1);
    write_reg(REG_FAR_CAP, 2);
    send(OP_GET, key_pool[0], 32'h0);
    send(OP_PUT, key_pool[0], 32'hffff_ffff);
    send(OP_PUT, key_pool[1], 32'h0);
    send(OP_PUT, key_pool[2], 32'h1234_5678);
    send(OP_PUT, key_pool[3], 32'h5555_aaaa);
    send(OP_GET, key_pool[3], 32'h0);
    send(OP_GET, key_pool[0], 32'h0);
    send(OP_GET, key_pool[1], 32'h0);
    send(OP_GET, key_pool[2], 32'h0);
    send(OP_PUT, key_pool[2], 32'haaaa_5555);
    send(OP_DEL, key_pool[0], 32'h0);
    send(OP_DEL, key_pool[4], 32'h0);
    send(2'd3, key_pool[1], 32'hffff_ffff);
    send(OP_GET, key_pool[1], 32'h0);
    drain();
    // Zero acts as one; then shrink below count
    write_reg(REG_NEAR_CAP, 0);
    write_reg(REG_FAR_CAP, 0);
    send(OP_PUT, key_pool[5], 32'h1);
    send(OP_PUT, key_pool[6], 32'h2);
    send(OP_GET, key_pool[5], 32'h0);
    drain();
    write_reg(REG_NEAR_CAP, 31);
    write_reg(REG_FAR_CAP, 127);

    idle_pct = 28;
    random_phase(250);
    drain();
    write_reg(REG_NEAR_CAP, 3);
    write_reg(REG_FAR_CAP, 5);
    idle_pct = 46;
    random_phase(250);
    drain();
    write_reg(REG_NEAR_CAP, 16);
    write_reg(REG_FAR_CAP, 64);
    idle_pct = 0;
    random_phase(125);
    drain();
    write_reg(REG_NEAR_CAP, 2);
    write_reg(REG_FAR_CAP, 1);
    random_phase(125);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("two_level_lru_key_cache_tb passed");
    end else begin
      $display("two_level_lru_key_cache_tb failed");
    end
    $finish;
  end

endmodule
